@@ hw/rtl/mted_pkg.sv @@
// Shared types and constants for the MIDI track event decoder.
package mted_pkg;

  // Default sizes
  localparam int TRACK_COUNT_DEF = 16;
  localparam int LENGTH_BITS_DEF = 28;

  // Fixed field widths
  localparam int TRACK_W  = 4;
  localparam int VALUE_W  = 28;
  localparam int TEMPO_W  = 24;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_TRANSPOSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_SCALE   = 1'b1;

  localparam logic [7:0] TRANSPOSE_RST = 8'd0;
  localparam logic [7:0] SCALE_RST     = 8'd128;

  // Per-track parser phase
  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SYSDATA  = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_TEMPO    = 4'd8,
    PH_SKIP     = 4'd9,
    PH_ENDED    = 4'd10
  } phase_t;

  // Event kinds
  localparam logic [2:0] KIND_DELTA   = 3'd0;
  localparam logic [2:0] KIND_CHANNEL = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_SYSBYTE = 3'd3;
  localparam logic [2:0] KIND_TEMPO   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  // Loop marks
  localparam logic [1:0] LOOP_NONE  = 2'd0;
  localparam logic [1:0] LOOP_START = 2'd1;
  localparam logic [1:0] LOOP_END   = 2'd2;

  // Status and meta codes
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
  localparam logic [7:0] META_END   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] CTRL_VOLUME = 8'd7;
  localparam logic [7:0] CTRL_BREATH = 8'd2;
  localparam logic [7:0] CTRL_FOOT   = 8'd4;
  localparam logic [8:0] VOL_MAX     = 9'd127;

endpackage

@@ hw/rtl/midi_track_event_decoder.sv @@
// MIDI track event decoder: per-track parser records, one byte word per cycle unless stalled.
//
// Bytes of standard MIDI file track data come in one word per cycle, each
// tagged with a track number, and every track keeps its own parser record
// (phase, running status, variable-length accumulator, byte count, meta type,
// held data byte, tempo shift register) in a small register file. A word is
// taken into an input register; from there the record of its track is
// read, updated by a short decode and written back, and any event lands in
// the output register. Throughput is one word per cycle with no gaps while
// the output is not stalled, even when consecutive words hit the same track,
// since each record write lands before the next word's read; the result word
// reaches the master side through the input register and the output
// register. Words that finish nothing (most
// length bytes, meta bytes, skipped meta data, restarts, track numbers at or
// beyond TRACK_COUNT) give no result word. The input side keeps accepting
// while a result waits, as long as the output register is free or drained in
// the same cycle. Events: delta time, channel message (notes transposed by
// note_transpose mod 256, controller 7 scaled by volume_scale/128 and
// clamped to 127, controllers 2 and 4 flagged as loop start and end), sysex
// start with length, sysex data bytes (tlast on the final one), tempo in
// microseconds per quarter note, and end of track; after end of track a
// track ignores data until restarted with tuser set. Reset clears every
// record at once; there is no clearing pass. Configuration writes are always
// accepted and should only be issued while the decoder is idle.
module midi_track_event_decoder #(
  parameter int TRACK_COUNT = mted_pkg::TRACK_COUNT_DEF,
  parameter int LENGTH_BITS = mted_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // track_index[3:0], data_byte[11:4], zero pad
  input  logic        s_tuser,   // action: 1 restarts the track
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // event_track[3:0], status_out[11:4],
                                 // first_data[19:12], second_data[27:20],
                                 // value_out[55:28], loop_mark[57:56], zero pad
  output logic [2:0]  m_tuser,   // event_kind
  output logic        m_tlast,   // last_byte
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mted_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int TRK_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int LB    = LENGTH_BITS;
  localparam logic [6:0] TRACK_LIMIT = 7'(TRACK_COUNT);

  // Configuration registers
  logic [7:0] transpose_q;
  logic [7:0] scale_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_q <= mted_pkg::TRANSPOSE_RST;
      scale_q     <= mted_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mted_pkg::REG_NOTE_TRANSPOSE: transpose_q <= cfg_data;
        mted_pkg::REG_VOLUME_SCALE:   scale_q     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                       a_valid;
  logic                       a_action;
  logic [mted_pkg::TRACK_W-1:0] a_track;
  logic [7:0]                 a_byte;

  // Output register
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [3:0]  out_track;
  logic [7:0]  out_status;
  logic [7:0]  out_first;
  logic [7:0]  out_second;
  logic [mted_pkg::VALUE_W-1:0] out_value;
  logic [1:0]  out_loop;
  logic        out_last;

  logic take;   // output register can load this cycle
  logic adv;    // input register word is processed this cycle

  assign take     = !out_valid || m_tready;
  assign adv      = a_valid && take;
  assign s_tready = !a_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_action <= s_tuser;
      a_track  <= s_tdata[3:0];
      a_byte   <= s_tdata[11:4];
    end
  end

  // Per-track parser records
  mted_pkg::phase_t    ph_q    [TRACK_COUNT];
  logic [7:0]          rs_q    [TRACK_COUNT];
  logic [LB-1:0]       len_q   [TRACK_COUNT];
  logic [LB-1:0]       rem_q   [TRACK_COUNT];
  logic [7:0]          meta_q  [TRACK_COUNT];
  logic [7:0]          first_q [TRACK_COUNT];
  logic [mted_pkg::TEMPO_W-1:0] tempo_q [TRACK_COUNT];

  logic [TRK_W-1:0] tidx;
  logic             in_range;

  assign tidx     = TRK_W'(a_track);
  assign in_range = (7'(a_track) < TRACK_LIMIT);

  // Current record
  mted_pkg::phase_t cur_ph;
  logic [7:0]    cur_rs;
  logic [LB-1:0] cur_len;
  logic [LB-1:0] cur_rem;
  logic [7:0]    cur_meta;
  logic [7:0]    cur_first;
  logic [mted_pkg::TEMPO_W-1:0] cur_tempo;

  // Decode after status handling
  mted_pkg::phase_t eff_ph;
  logic [7:0]    eff_rs;
  logic [LB-1:0] eff_len;
  logic [7:0]    sel_st;
  logic          feed;
  logic [LB-1:0] acc;
  logic          vlq_done;
  logic          acc_zero;
  logic [LB-1:0] rem_dec;
  logic          rem_done;
  logic [mted_pkg::TEMPO_W-1:0] tempo_new;
  logic          one_byte;

  // Channel message fields
  logic [7:0]  ch_d1_in;
  logic [7:0]  ch_d2_in;
  logic [7:0]  ch_d1;
  logic [7:0]  ch_d2;
  logic [1:0]  ch_loop;
  logic [15:0] vol_prod;
  logic [8:0]  vol_q;

  always_comb begin : decode_blk
    cur_ph    = ph_q[tidx];
    cur_rs    = rs_q[tidx];
    cur_len   = len_q[tidx];
    cur_rem   = rem_q[tidx];
    cur_meta  = meta_q[tidx];
    cur_first = first_q[tidx];
    cur_tempo = tempo_q[tidx];

    feed    = !a_action;
    eff_ph  = cur_ph;
    eff_rs  = cur_rs;
    eff_len = cur_len;
    sel_st  = a_byte[7] ? a_byte : cur_rs;

    // Status position: a status byte is taken; a data byte reruns under
    // running status as the first byte of the selected event.
    if (!a_action && cur_ph == mted_pkg::PH_STATUS) begin
      feed    = !a_byte[7];
      eff_len = '0;
      if (sel_st == mted_pkg::ST_META) begin
        eff_ph = mted_pkg::PH_METATYPE;
      end else begin
        eff_rs = sel_st;
        if (sel_st == mted_pkg::ST_SYSEX) begin
          eff_ph = mted_pkg::PH_SYSLEN;
        end else if (sel_st[7] && sel_st[7:4] != mted_pkg::TYPE_SYSTEM) begin
          eff_ph = mted_pkg::PH_DATA1;
        end else begin
          eff_ph = mted_pkg::PH_DELTA;
        end
      end
    end

    acc       = LB'({eff_len, a_byte[6:0]});
    vlq_done  = !a_byte[7];
    acc_zero  = (acc == '0);
    rem_dec   = cur_rem - LB'(1);
    rem_done  = (rem_dec == '0);
    tempo_new = {cur_tempo[15:0], a_byte};
    one_byte  = (eff_rs[7:4] == mted_pkg::TYPE_PROGRAM) ||
                (eff_rs[7:4] == mted_pkg::TYPE_PRESSURE);
  end

  always_comb begin : channel_blk
    ch_d1_in = (eff_ph == mted_pkg::PH_DATA2) ? cur_first : a_byte;
    ch_d2_in = (eff_ph == mted_pkg::PH_DATA2) ? a_byte : 8'd0;
    vol_prod = 16'(ch_d2_in) * 16'(scale_q);
    vol_q    = vol_prod[15:7];
    ch_d1    = ch_d1_in;
    ch_d2    = ch_d2_in;
    ch_loop  = mted_pkg::LOOP_NONE;
    if (eff_rs[7:4] == mted_pkg::TYPE_NOTE_OFF || eff_rs[7:4] == mted_pkg::TYPE_NOTE_ON) begin
      ch_d1 = ch_d1_in + transpose_q;
    end
    if (eff_rs[7:4] == mted_pkg::TYPE_CTRL) begin
      if (ch_d1_in == mted_pkg::CTRL_VOLUME) begin
        ch_d2 = (vol_q > mted_pkg::VOL_MAX) ? 8'(mted_pkg::VOL_MAX) : 8'(vol_q);
      end else if (ch_d1_in == mted_pkg::CTRL_BREATH) begin
        ch_loop = mted_pkg::LOOP_START;
      end else if (ch_d1_in == mted_pkg::CTRL_FOOT) begin
        ch_loop = mted_pkg::LOOP_END;
      end
    end
  end

  // Next record
  mted_pkg::phase_t n_ph;
  logic [7:0]    n_rs;
  logic [LB-1:0] n_len;
  logic [LB-1:0] n_rem;
  logic [7:0]    n_meta;
  logic [7:0]    n_first;
  logic [mted_pkg::TEMPO_W-1:0] n_tempo;
  logic          meta_finish;

  always_comb begin : next_state_blk
    n_ph        = eff_ph;
    n_rs        = eff_rs;
    n_len       = eff_len;
    n_rem       = cur_rem;
    n_meta      = cur_meta;
    n_first     = cur_first;
    n_tempo     = cur_tempo;
    meta_finish = 1'b0;

    if (a_action) begin
      n_ph    = mted_pkg::PH_DELTA;
      n_rs    = cur_rs;
      n_len   = '0;
      n_rem   = '0;
      n_tempo = '0;
    end else if (feed) begin
      unique case (eff_ph)
        mted_pkg::PH_DELTA: begin
          n_len = acc;
          if (vlq_done) begin
            n_len = '0;
            n_ph  = mted_pkg::PH_STATUS;
          end
        end
        mted_pkg::PH_DATA1: begin
          if (one_byte) begin
            n_ph  = mted_pkg::PH_DELTA;
            n_len = '0;
          end else begin
            n_first = a_byte;
            n_ph    = mted_pkg::PH_DATA2;
          end
        end
        mted_pkg::PH_DATA2: begin
          n_ph  = mted_pkg::PH_DELTA;
          n_len = '0;
        end
        mted_pkg::PH_SYSLEN: begin
          n_len = acc;
          if (vlq_done) begin
            n_len = '0;
            n_rem = acc;
            n_ph  = acc_zero ? mted_pkg::PH_DELTA : mted_pkg::PH_SYSDATA;
          end
        end
        mted_pkg::PH_SYSDATA: begin
          n_rem = rem_dec;
          if (rem_done) begin
            n_ph  = mted_pkg::PH_DELTA;
            n_len = '0;
          end
        end
        mted_pkg::PH_METATYPE: begin
          n_meta = a_byte;
          n_len  = '0;
          n_ph   = mted_pkg::PH_METALEN;
        end
        mted_pkg::PH_METALEN: begin
          n_len = acc;
          if (vlq_done) begin
            n_len = '0;
            if (cur_meta == mted_pkg::META_END) begin
              n_ph = mted_pkg::PH_ENDED;
            end else begin
              n_rem = acc;
              if (cur_meta == mted_pkg::META_TEMPO) begin
                n_tempo = '0;
                if (acc_zero) meta_finish = 1'b1;
                else          n_ph = mted_pkg::PH_TEMPO;
              end else begin
                if (acc_zero) meta_finish = 1'b1;
                else          n_ph = mted_pkg::PH_SKIP;
              end
            end
          end
        end
        mted_pkg::PH_TEMPO: begin
          n_tempo = tempo_new;
          n_rem   = rem_dec;
          meta_finish = rem_done;
        end
        mted_pkg::PH_SKIP: begin
          n_rem       = rem_dec;
          meta_finish = rem_done;
        end
        default: ;
      endcase
      // completed meta event: 0xFF becomes running status
      if (meta_finish) begin
        n_rs  = mted_pkg::ST_META;
        n_ph  = mted_pkg::PH_DELTA;
        n_len = '0;
      end
    end
  end

  // Result of this word
  logic        res_emit;
  logic [2:0]  res_kind;
  logic [7:0]  res_status;
  logic [7:0]  res_first;
  logic [7:0]  res_second;
  logic [mted_pkg::VALUE_W-1:0] res_value;
  logic [1:0]  res_loop;
  logic        res_last;

  always_comb begin : output_blk
    res_emit   = 1'b0;
    res_kind   = mted_pkg::KIND_DELTA;
    res_status = 8'd0;
    res_first  = 8'd0;
    res_second = 8'd0;
    res_value  = '0;
    res_loop   = mted_pkg::LOOP_NONE;
    res_last   = 1'b0;
    if (in_range && feed) begin
      unique case (eff_ph) inside
        mted_pkg::PH_DELTA: begin
          res_emit  = vlq_done;
          res_value = mted_pkg::VALUE_W'(acc);
        end
        mted_pkg::PH_DATA1, mted_pkg::PH_DATA2: begin
          res_emit   = (eff_ph == mted_pkg::PH_DATA2) || one_byte;
          res_kind   = mted_pkg::KIND_CHANNEL;
          res_status = eff_rs;
          res_first  = ch_d1;
          res_second = ch_d2;
          res_loop   = ch_loop;
        end
        mted_pkg::PH_SYSLEN: begin
          res_emit   = vlq_done;
          res_kind   = mted_pkg::KIND_SYSEX;
          res_status = mted_pkg::ST_SYSEX;
          res_value  = mted_pkg::VALUE_W'(acc);
        end
        mted_pkg::PH_SYSDATA: begin
          res_emit   = 1'b1;
          res_kind   = mted_pkg::KIND_SYSBYTE;
          res_status = mted_pkg::ST_SYSEX;
          res_first  = a_byte;
          res_last   = rem_done;
        end
        mted_pkg::PH_METALEN: begin
          res_status = mted_pkg::ST_META;
          if (vlq_done && cur_meta == mted_pkg::META_END) begin
            res_emit = 1'b1;
            res_kind = mted_pkg::KIND_END;
          end else if (vlq_done && cur_meta == mted_pkg::META_TEMPO && acc_zero) begin
            res_emit = 1'b1;
            res_kind = mted_pkg::KIND_TEMPO;
          end
        end
        mted_pkg::PH_TEMPO: begin
          res_emit   = rem_done;
          res_kind   = mted_pkg::KIND_TEMPO;
          res_status = mted_pkg::ST_META;
          res_value  = mted_pkg::VALUE_W'(tempo_new);
        end
        default: ;
      endcase
    end
  end

  // Record write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        ph_q[i]    <= mted_pkg::PH_DELTA;
        rs_q[i]    <= '0;
        len_q[i]   <= '0;
        rem_q[i]   <= '0;
        meta_q[i]  <= '0;
        first_q[i] <= '0;
        tempo_q[i] <= '0;
      end
    end else if (adv && in_range) begin
      ph_q[tidx]    <= n_ph;
      rs_q[tidx]    <= n_rs;
      len_q[tidx]   <= n_len;
      rem_q[tidx]   <= n_rem;
      meta_q[tidx]  <= n_meta;
      first_q[tidx] <= n_first;
      tempo_q[tidx] <= n_tempo;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= a_valid && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_emit) begin
      out_kind   <= res_kind;
      out_track  <= a_track;
      out_status <= res_status;
      out_first  <= res_first;
      out_second <= res_second;
      out_value  <= res_value;
      out_loop   <= res_loop;
      out_last   <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_loop, out_value, out_second, out_first, out_status, out_track};

  // Checks
  a_rst_clears: assert property (@(posedge clk) rst |=> !a_valid && !m_tvalid)
    else $error("valid flags not cleared by reset");

  a_last_sysbyte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == mted_pkg::KIND_SYSBYTE)
    else $error("last flag on a non-sysex word");

  a_loop_ctrl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[57:56] != mted_pkg::LOOP_NONE |->
      m_tuser == mted_pkg::KIND_CHANNEL && m_tdata[11:8] == mted_pkg::TYPE_CTRL)
    else $error("loop mark outside a controller message");

  a_vol_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mted_pkg::KIND_CHANNEL && m_tdata[11:8] == mted_pkg::TYPE_CTRL
      && m_tdata[19:12] == mted_pkg::CTRL_VOLUME |-> !m_tdata[27])
    else $error("scaled volume above 127");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    a_valid && out_valid && !m_tready |=> $stable(a_byte) && a_valid)
    else $error("input register overwritten while stalled");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the MIDI track event decoder.
`timescale 1ns / 100ps

module tb_top;

  // Word-level codes for the input side
  localparam logic ACT_FEED    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam int RAND_PER_PHASE = 425;  // four pacing phases, ~1700 random words
  localparam int LATENCY_WAIT   = 4;    // margin past the decoder's input and output registers

  // One decoded event, field for field as it leaves the block
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  trk;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [27:0] value;
    logic [1:0]  loop;
    logic        last;
  } event_t;

  // How a word's expectation is formed: from the predictor, or typed in the table
  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_EVENT} row_mode_t;

  typedef struct packed {
    row_mode_t  mode;
    logic       act;
    logic [3:0] trk;
    logic [7:0] b;
    event_t     ev;
  } stim_row_t;

  typedef struct packed {
    row_mode_t mode;
    event_t    ev;
  } word_note_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // track_index[3:0], data_byte[11:4], zero pad
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // track, status, first, second, value, loop_mark
  logic [2:0]  m_tuser;        // event_kind
  logic        m_tlast;        // last_byte
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [mted_pkg::CFG_IDX_W-1:0] cfg_index = mted_pkg::REG_NOTE_TRANSPOSE;
  logic [7:0]  cfg_data = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  midi_track_event_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: one parser record per track plus the two registers.
  // ---------------------------------------------------------------------------
  mted_pkg::phase_t trk_phase [16];
  logic [7:0]  trk_run   [16];   // running status
  logic [27:0] trk_len   [16];   // variable-length accumulator
  logic [27:0] trk_left  [16];   // bytes still owed by sysex / meta
  logic [7:0]  trk_meta  [16];
  logic [7:0]  trk_held  [16];   // first data byte of a two-byte message
  logic [23:0] trk_tempo [16];
  logic [7:0]  cur_transpose = mted_pkg::TRANSPOSE_RST;
  logic [7:0]  cur_scale     = mted_pkg::SCALE_RST;

  // Scoreboard and bookkeeping
  event_t      pending_events [$];
  word_note_t  word_notes [$];
  stim_row_t   dir_rows [$];
  logic [8:0]  track_bytes [16][$];  // {action, byte} still to send per track
  int          error_count = 0;
  int          events_checked = 0;
  int          words_sent = 0;
  int          kind_seen [0:7];
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  word_note_t  note_in;
  event_t      predicted;
  event_t      observed;
  event_t      want;
  logic        got_hit;

  initial begin
    for (int i = 0; i < 16; i++) begin
      trk_phase[i] = mted_pkg::PH_DELTA;
      trk_run[i]   = '0;
      trk_len[i]   = '0;
      trk_left[i]  = '0;
      trk_meta[i]  = '0;
      trk_held[i]  = '0;
      trk_tempo[i] = '0;
    end
    for (int i = 0; i < 8; i++) kind_seen[i] = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Status byte taken in status position (or running status replayed).
  // 0xFF never becomes running status here; it is set when a meta closes.
  task automatic enter_status(input logic [3:0] t, input logic [7:0] st);
    trk_len[t] = '0;
    if (st == mted_pkg::ST_META) begin
      trk_phase[t] = mted_pkg::PH_METATYPE;
    end else begin
      trk_run[t] = st;
      if (st == mted_pkg::ST_SYSEX)
        trk_phase[t] = mted_pkg::PH_SYSLEN;
      else if (st[7:4] >= mted_pkg::TYPE_NOTE_OFF && st[7:4] < mted_pkg::TYPE_SYSTEM)
        trk_phase[t] = mted_pkg::PH_DATA1;
      else
        trk_phase[t] = mted_pkg::PH_DELTA;  // system 0xF1..0xFE, or running status < 0x80
    end
  endtask

  task automatic close_meta(input logic [3:0] t);
    trk_run[t]   = mted_pkg::ST_META;
    trk_phase[t] = mted_pkg::PH_DELTA;
    trk_len[t]   = '0;
  endtask

  // Channel message: transpose notes, scale/clamp volume, flag loop controllers
  task automatic chan_event(input logic [3:0] t, input logic [7:0] a, input logic [7:0] c,
                            inout event_t ev);
    logic [15:0] prod;
    logic [3:0]  kind_hi;
    kind_hi = trk_run[t][7:4];
    ev.loop = mted_pkg::LOOP_NONE;
    if (kind_hi == mted_pkg::TYPE_NOTE_OFF || kind_hi == mted_pkg::TYPE_NOTE_ON)
      a = a + cur_transpose;
    if (kind_hi == mted_pkg::TYPE_CTRL) begin
      if (a == mted_pkg::CTRL_VOLUME) begin
        prod = (c * cur_scale) >> 7;
        c = (prod > 16'(mted_pkg::VOL_MAX)) ? mted_pkg::VOL_MAX[7:0] : prod[7:0];
      end else if (a == mted_pkg::CTRL_BREATH) begin
        ev.loop = mted_pkg::LOOP_START;
      end else if (a == mted_pkg::CTRL_FOOT) begin
        ev.loop = mted_pkg::LOOP_END;
      end
    end
    trk_phase[t] = mted_pkg::PH_DELTA;
    trk_len[t]   = '0;
    ev.kind   = mted_pkg::KIND_CHANNEL;
    ev.status = trk_run[t];
    ev.d1     = a;
    ev.d2     = c;
  endtask

  // One accepted word in, at most one event out
  task automatic decode_word(input logic act, input logic [3:0] t, input logic [7:0] b,
                             output logic hit, output event_t ev);
    logic [27:0] v;
    hit = 1'b0;
    ev  = '0;
    ev.trk = t;
    if (act) begin
      // restart keeps running status
      trk_phase[t] = mted_pkg::PH_DELTA;
      trk_len[t]   = '0;
      trk_left[t]  = '0;
      trk_tempo[t] = '0;
      return;
    end
    if (trk_phase[t] == mted_pkg::PH_STATUS) begin
      if (b[7]) begin
        enter_status(t, b);
        return;
      end
      enter_status(t, trk_run[t]);  // byte is replayed below
    end
    case (trk_phase[t])
      mted_pkg::PH_DELTA: begin
        trk_len[t] = {trk_len[t][20:0], b[6:0]};
        if (!b[7]) begin
          hit = 1'b1;
          ev.kind  = mted_pkg::KIND_DELTA;
          ev.value = trk_len[t];
          trk_len[t]   = '0;
          trk_phase[t] = mted_pkg::PH_STATUS;
        end
      end
      mted_pkg::PH_DATA1: begin
        if (trk_run[t][7:4] == mted_pkg::TYPE_PROGRAM ||
            trk_run[t][7:4] == mted_pkg::TYPE_PRESSURE) begin
          chan_event(t, b, 8'h00, ev);
          hit = 1'b1;
        end else begin
          trk_held[t]  = b;
          trk_phase[t] = mted_pkg::PH_DATA2;
        end
      end
      mted_pkg::PH_DATA2: begin
        chan_event(t, trk_held[t], b, ev);
        hit = 1'b1;
      end
      mted_pkg::PH_SYSLEN: begin
        trk_len[t] = {trk_len[t][20:0], b[6:0]};
        if (!b[7]) begin
          v = trk_len[t];
          trk_len[t]   = '0;
          trk_left[t]  = v;
          trk_phase[t] = (v == 0) ? mted_pkg::PH_DELTA : mted_pkg::PH_SYSDATA;
          hit = 1'b1;
          ev.kind   = mted_pkg::KIND_SYSEX;
          ev.status = mted_pkg::ST_SYSEX;
          ev.value  = v;
        end
      end
      mted_pkg::PH_SYSDATA: begin
        trk_left[t] = trk_left[t] - 1'b1;
        if (trk_left[t] == 0) begin
          trk_phase[t] = mted_pkg::PH_DELTA;
          trk_len[t]   = '0;
        end
        hit = 1'b1;
        ev.kind   = mted_pkg::KIND_SYSBYTE;
        ev.status = mted_pkg::ST_SYSEX;
        ev.d1     = b;
        ev.last   = (trk_left[t] == 0);
      end
      mted_pkg::PH_METATYPE: begin
        trk_meta[t]  = b;
        trk_len[t]   = '0;
        trk_phase[t] = mted_pkg::PH_METALEN;
      end
      mted_pkg::PH_METALEN: begin
        trk_len[t] = {trk_len[t][20:0], b[6:0]};
        if (!b[7]) begin
          v = trk_len[t];
          trk_len[t] = '0;
          if (trk_meta[t] == mted_pkg::META_END) begin
            // length ignored, track goes quiet until restarted
            trk_phase[t] = mted_pkg::PH_ENDED;
            hit = 1'b1;
            ev.kind   = mted_pkg::KIND_END;
            ev.status = mted_pkg::ST_META;
          end else begin
            trk_left[t] = v;
            if (trk_meta[t] == mted_pkg::META_TEMPO) begin
              trk_tempo[t] = '0;
              if (v == 0) begin
                close_meta(t);
                hit = 1'b1;
                ev.kind   = mted_pkg::KIND_TEMPO;
                ev.status = mted_pkg::ST_META;
              end else begin
                trk_phase[t] = mted_pkg::PH_TEMPO;
              end
            end else if (v == 0) begin
              close_meta(t);
            end else begin
              trk_phase[t] = mted_pkg::PH_SKIP;
            end
          end
        end
      end
      mted_pkg::PH_TEMPO: begin
        trk_tempo[t] = {trk_tempo[t][15:0], b};
        trk_left[t]  = trk_left[t] - 1'b1;
        if (trk_left[t] == 0) begin
          close_meta(t);
          hit = 1'b1;
          ev.kind   = mted_pkg::KIND_TEMPO;
          ev.status = mted_pkg::ST_META;
          ev.value  = {4'h0, trk_tempo[t]};
        end
      end
      mted_pkg::PH_SKIP: begin
        trk_left[t] = trk_left[t] - 1'b1;
        if (trk_left[t] == 0) close_meta(t);
      end
      default: ;  // ended track: ignore
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on input accept, track config writes, check result words.
  // All sampling at the rising edge sees pre-edge values.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [27:0] got,
                             input logic [27:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("track %0d %s: got %0h, expected %0h",
                             observed.trk, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        note_in = word_notes.pop_front();
        decode_word(s_tuser, s_tdata[3:0], s_tdata[11:4], got_hit, predicted);
        if (note_in.mode == ROW_EVENT) pending_events.push_back(note_in.ev);
        else if (note_in.mode == ROW_PREDICT && got_hit) pending_events.push_back(predicted);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mted_pkg::REG_NOTE_TRANSPOSE) cur_transpose = cfg_data;
        else if (cfg_index == mted_pkg::REG_VOLUME_SCALE) cur_scale = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        observed.kind   = m_tuser;
        observed.trk    = m_tdata[3:0];
        observed.status = m_tdata[11:4];
        observed.d1     = m_tdata[19:12];
        observed.d2     = m_tdata[27:20];
        observed.value  = m_tdata[55:28];
        observed.loop   = m_tdata[57:56];
        observed.last   = m_tlast;
        events_checked++;
        kind_seen[m_tuser]++;
        if (pending_events.size() == 0) begin
          report_error($sformatf("unexpected event kind %0d on track %0d",
                                 observed.kind, observed.trk));
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind",  28'(observed.kind),   28'(want.kind));
          check_field("event_track", 28'(observed.trk),    28'(want.trk));
          check_field("status_out",  28'(observed.status), 28'(want.status));
          check_field("first_data",  28'(observed.d1),     28'(want.d1));
          check_field("second_data", 28'(observed.d2),     28'(want.d2));
          check_field("value_out",   observed.value,       want.value);
          check_field("loop_mark",   28'(observed.loop),   28'(want.loop));
          check_field("last_byte",   28'(observed.last),   28'(want.last));
        end
      end
    end
  end

  // Receiver: random backpressure at the current stall rate
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one word; valid stays high into the next call unless a gap is drawn.
  task automatic put_word(input logic act, input logic [3:0] trk, input logic [7:0] b,
                          input row_mode_t mode, input event_t ev);
    word_note_t note;
    note.mode = mode;
    note.ev   = ev;
    word_notes.push_back(note);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, b, trk};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Hold the sender off until every expected event is out, then let the
  // pipeline empty of words that produce nothing.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mted_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_row(input row_mode_t mode, input logic act, input logic [3:0] trk,
                         input logic [7:0] b, input logic [2:0] kind = mted_pkg::KIND_DELTA,
                         input logic [7:0] st = 8'h00, input logic [7:0] d1 = 8'h00,
                         input logic [7:0] d2 = 8'h00, input logic [27:0] val = '0,
                         input logic [1:0] loop = mted_pkg::LOOP_NONE,
                         input logic last = 1'b0);
    stim_row_t r;
    r.mode = mode;
    r.act  = act;
    r.trk  = trk;
    r.b    = b;
    r.ev   = '{kind, trk, st, d1, d2, val, loop, last};
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_data();
    // mostly proper data bytes, now and then the high bit set
    return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
  endfunction

  task automatic push_byte(input int t, input logic [7:0] b);
    track_bytes[t].push_back({ACT_FEED, b});
  endtask

  // Variable-length quantity, n groups of 7 bits, top group first
  task automatic push_vlq(input int t, input logic [34:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(t, {(i != 0), 7'(v >> (7 * i))});
  endtask

  // Queue one well-formed delta + event for track t, with random content
  task automatic queue_event(input int t);
    int         pick;
    int         n;
    int         len;
    logic [7:0] st;
    logic [7:0] mt;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) track_bytes[t].push_back({ACT_RESTART, 8'($urandom)});
    n = ($urandom_range(9) < 7) ? 1 : $urandom_range(5, 2);  // five groups wrap
    push_vlq(t, {3'($urandom), 32'($urandom)}, n);
    if (pick < 45) begin
      // channel message, status left out a quarter of the time (running status)
      st = 8'h80 + 8'($urandom_range(8'h6F));
      if ($urandom_range(3) != 0) push_byte(t, st);
      case ($urandom_range(5))
        0:       push_byte(t, mted_pkg::CTRL_VOLUME);
        1:       push_byte(t, mted_pkg::CTRL_BREATH);
        2:       push_byte(t, mted_pkg::CTRL_FOOT);
        default: push_byte(t, rand_data());
      endcase
      if (st[7:4] != mted_pkg::TYPE_PROGRAM && st[7:4] != mted_pkg::TYPE_PRESSURE)
        push_byte(t, rand_data());
    end else if (pick < 58) begin
      push_byte(t, mted_pkg::ST_SYSEX);
      len = $urandom_range(5);
      push_vlq(t, 35'(len), ($urandom_range(3) == 0) ? 2 : 1);
      repeat (len) push_byte(t, 8'($urandom));
    end else if (pick < 70) begin
      push_byte(t, mted_pkg::ST_META);
      push_byte(t, mted_pkg::META_TEMPO);
      len = ($urandom_range(3) == 0) ? $urandom_range(4) : 3;
      push_vlq(t, 35'(len), 1);
      repeat (len) push_byte(t, 8'($urandom));
    end else if (pick < 82) begin
      // other meta, skipped unless the type is tempo
      push_byte(t, mted_pkg::ST_META);
      mt = 8'($urandom);
      if (mt == mted_pkg::META_END) mt = mted_pkg::META_TEMPO;
      push_byte(t, mt);
      len = $urandom_range(4);
      push_vlq(t, 35'(len), 1);
      repeat (len) push_byte(t, 8'($urandom));
    end else if (pick < 92) begin
      push_byte(t, {mted_pkg::TYPE_SYSTEM, 4'($urandom_range(14, 1))});
    end else begin
      // end of track, a few ignored bytes, then restart
      push_byte(t, mted_pkg::ST_META);
      push_byte(t, mted_pkg::META_END);
      push_vlq(t, 35'($urandom_range(2)), 1);
      repeat ($urandom_range(2)) push_byte(t, 8'($urandom));
      track_bytes[t].push_back({ACT_RESTART, 8'($urandom)});
    end
  endtask

  // Tracks interleave word by word; a few words are pure noise or cut sequences
  task automatic random_words(input int count);
    int         t;
    logic [8:0] w;
    for (int i = 0; i < count; i++) begin
      t = $urandom_range(15);
      if ($urandom_range(99) < 5) begin
        put_word($urandom_range(3) == 0, 4'(t), 8'($urandom), ROW_PREDICT, '0);
      end else begin
        if ($urandom_range(99) == 0) begin
          track_bytes[t].delete();
          track_bytes[t].push_back({ACT_RESTART, 8'($urandom)});
        end
        if (track_bytes[t].size() == 0) queue_event(t);
        w = track_bytes[t].pop_front();
        put_word(w[8], 4'(t), w[7:0], ROW_PREDICT, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed table. Typed rows carry their expected event; the rest
    // go through the predictor.
    // track 0: note at extremes, volume clamp with a high data byte,
    // loop start through running status
    add_row(ROW_EVENT,  ACT_FEED, 4'd0, 8'h00, mted_pkg::KIND_DELTA);
    add_row(ROW_SILENT, ACT_FEED, 4'd0, {mted_pkg::TYPE_NOTE_ON, 4'h3});
    add_row(ROW_SILENT, ACT_FEED, 4'd0, 8'h00);
    add_row(ROW_EVENT,  ACT_FEED, 4'd0, 8'h7F, mted_pkg::KIND_CHANNEL,
            {mted_pkg::TYPE_NOTE_ON, 4'h3}, 8'h00, 8'h7F);
    add_row(ROW_EVENT,  ACT_FEED, 4'd0, 8'h00, mted_pkg::KIND_DELTA);
    add_row(ROW_SILENT, ACT_FEED, 4'd0, {mted_pkg::TYPE_CTRL, 4'hF});
    add_row(ROW_SILENT, ACT_FEED, 4'd0, mted_pkg::CTRL_VOLUME);
    add_row(ROW_EVENT,  ACT_FEED, 4'd0, 8'hFF, mted_pkg::KIND_CHANNEL,
            {mted_pkg::TYPE_CTRL, 4'hF}, mted_pkg::CTRL_VOLUME, mted_pkg::VOL_MAX[7:0]);
    add_row(ROW_PREDICT, ACT_FEED, 4'd0, 8'h00);
    add_row(ROW_PREDICT, ACT_FEED, 4'd0, mted_pkg::CTRL_BREATH);
    add_row(ROW_PREDICT, ACT_FEED, 4'd0, 8'h80);
    // track 15: longest delta, empty sysex, empty tempo
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'hFF);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'hFF);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'hFF);
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h7F, mted_pkg::KIND_DELTA, 8'h00, 8'h00, 8'h00,
            28'hFFF_FFFF);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, mted_pkg::ST_SYSEX);
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h00, mted_pkg::KIND_SYSEX, mted_pkg::ST_SYSEX);
    add_row(ROW_PREDICT, ACT_FEED, 4'd15, 8'h00);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, mted_pkg::ST_META);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, mted_pkg::META_TEMPO);
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h00, mted_pkg::KIND_TEMPO, mted_pkg::ST_META);
    // running status is now meta: a data byte in status position is a meta type
    add_row(ROW_PREDICT, ACT_FEED, 4'd15, 8'h00);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'h7F);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'h00);
    // system status drops back to delta time
    add_row(ROW_PREDICT, ACT_FEED, 4'd15, 8'h00);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, {mted_pkg::TYPE_SYSTEM, 4'hE});
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h05, mted_pkg::KIND_DELTA, 8'h00, 8'h00, 8'h00,
            28'd5);
    // restart in the middle of a delta clears the accumulator
    add_row(ROW_SILENT, ACT_FEED, 4'd15, {mted_pkg::TYPE_SYSTEM, 4'hE});
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'h81);
    add_row(ROW_SILENT, ACT_RESTART, 4'd15, 8'hFF);
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h00, mted_pkg::KIND_DELTA);
    // end of track: length ignored, later bytes dropped
    add_row(ROW_SILENT, ACT_FEED, 4'd15, mted_pkg::ST_META);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, mted_pkg::META_END);
    add_row(ROW_EVENT,  ACT_FEED, 4'd15, 8'h05, mted_pkg::KIND_END, mted_pkg::ST_META);
    add_row(ROW_SILENT, ACT_FEED, 4'd15, 8'h00);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset register values, no idling
    foreach (dir_rows[i])
      put_word(dir_rows[i].act, dir_rows[i].trk, dir_rows[i].b, dir_rows[i].mode,
               dir_rows[i].ev);
    drain();

    // random part: four pacing modes, each with its own register setting
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(mted_pkg::REG_NOTE_TRANSPOSE, 8'h7F);
          write_reg(mted_pkg::REG_VOLUME_SCALE, 8'd0);
        end
        1: begin
          sender_idle_pct = 64; recv_stall_pct = 0;
          write_reg(mted_pkg::REG_NOTE_TRANSPOSE, 8'h80);
          write_reg(mted_pkg::REG_VOLUME_SCALE, mted_pkg::SCALE_RST);
        end
        2: begin
          sender_idle_pct = 0;  recv_stall_pct = 64;
          write_reg(mted_pkg::REG_NOTE_TRANSPOSE, 8'($urandom));
          write_reg(mted_pkg::REG_VOLUME_SCALE, 8'($urandom_range(128)));
        end
        default: begin
          sender_idle_pct = 31; recv_stall_pct = 31;
          write_reg(mted_pkg::REG_NOTE_TRANSPOSE, mted_pkg::TRANSPOSE_RST);
          write_reg(mted_pkg::REG_VOLUME_SCALE, 8'($urandom_range(128)));
        end
      endcase
      random_words(RAND_PER_PHASE);
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0)
      report_error($sformatf("%0d events never arrived", pending_events.size()));

    $display("summary: %0d track words (%0d directed), %0d events checked, 4 pacing modes",
             words_sent, dir_rows.size(), events_checked);
    $display("summary: delta %0d, channel %0d, sysex %0d, sysex data %0d, tempo %0d, end %0d",
             kind_seen[mted_pkg::KIND_DELTA], kind_seen[mted_pkg::KIND_CHANNEL],
             kind_seen[mted_pkg::KIND_SYSEX], kind_seen[mted_pkg::KIND_SYSBYTE],
             kind_seen[mted_pkg::KIND_TEMPO], kind_seen[mted_pkg::KIND_END]);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d events outstanding", pending_events.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
